/* rtl/evad_pkg.sv */
// Shared constants and types for the energy VAD endpoint detector.
package evad_pkg;

  localparam int ENERGY_W          = 31;
  localparam int SAMPLE_W          = 16;
  localparam int CHUNK_INDEX_W     = 32;
  localparam int COUNT8_W          = 8;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 31;
  localparam int CHUNK_SAMPLES_DEF = 640;

  localparam logic [ENERGY_W-1:0] THRESHOLD_RESET     = 31'd200000;
  localparam logic [COUNT8_W-1:0] MIN_CHUNKS_RESET    = 8'd38;
  localparam logic [COUNT8_W-1:0] SILENCE_LIMIT_RESET = 8'd25;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_THRESHOLD     = 2'd0,
    REG_MIN_CHUNKS    = 2'd1,
    REG_SILENCE_LIMIT = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    STOP_NONE = 2'd0,
    STOP_TAP  = 2'd1,
    STOP_AUTO = 2'd2
  } stop_cause_t;

endpackage

/* rtl/energy_vad_endpoint_detector_unit.sv */
// Top level of the energy VAD endpoint detector: sequencer, accumulator and result register.
//
//   channel   direction  handshake              payload
//   in        input      in_valid / in_ready    kind, sample, chunk_end
//   out       output     out_valid / out_ready  chunk_index, energy, silent,
//                                               final_marker, stop_cause
//   cfg       input      cfg_we (no wait)       cfg_index, cfg_data
//
// A sample is accepted, squared and accumulated. A sample that closes a chunk
// then passes through the one-bit-per-cycle divider (launch, 31 steps, done
// flag) and the result load; an automatic end adds the end-of-turn load.
// A tap that ends a turn also passes through the end-of-turn load.
// Reset restores the register defaults and clears all counters.
// A result waits in the output register while the next item is taken; the
// sequencer stalls only when it must load a result into a still-full register.
module energy_vad_endpoint_detector_unit
  import evad_pkg::*;
#(
  parameter int CHUNK_SAMPLES = CHUNK_SAMPLES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       kind,
  input  logic signed [SAMPLE_W-1:0] sample,
  input  logic                       chunk_end,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [CHUNK_INDEX_W-1:0]   chunk_index,
  output logic [ENERGY_W-1:0]        energy,
  output logic                       silent,
  output logic                       final_marker,
  output logic [1:0]                 stop_cause,
  input  logic                       cfg_we,
  input  logic [CFG_INDEX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data
);

  localparam int CNT_W = $clog2(CHUNK_SAMPLES + 1);
  localparam int SUM_W = ENERGY_W + CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_CHUNK,
    ST_FINAL
  } state_t;

  state_t state;

  logic [ENERGY_W-1:0]      energy_threshold;
  logic [COUNT8_W-1:0]      min_chunks;
  logic [COUNT8_W-1:0]      silence_limit;

  logic                     listening;
  logic [SUM_W-1:0]         square_sum;
  logic [CNT_W-1:0]         samples_in_chunk;
  logic [COUNT8_W-1:0]      chunks_seen;
  logic [COUNT8_W-1:0]      silent_run;
  logic [CHUNK_INDEX_W-1:0] next_chunk_index;
  stop_cause_t              end_cause;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic                     chunk_end_r;
  logic [ENERGY_W-1:0]      square;
  logic signed [2*SAMPLE_W-1:0] square_full;

  logic                     div_start;
  logic                     div_done;
  logic [ENERGY_W-1:0]      quotient;

  logic                     slot_free;
  logic                     load_out;
  logic [CNT_W-1:0]         cnt_inc;
  logic                     chunk_close;
  logic                     chunk_silent;
  logic [COUNT8_W-1:0]      chunks_seen_next;
  logic [COUNT8_W-1:0]      run_inc;
  logic [COUNT8_W-1:0]      silent_run_next;
  logic                     counting;
  logic                     auto_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      energy_threshold <= THRESHOLD_RESET;
      min_chunks       <= MIN_CHUNKS_RESET;
      silence_limit    <= SILENCE_LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_THRESHOLD:     energy_threshold <= cfg_data[ENERGY_W-1:0];
        REG_MIN_CHUNKS:    min_chunks       <= cfg_data[COUNT8_W-1:0];
        REG_SILENCE_LIMIT: silence_limit    <= cfg_data[COUNT8_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    slot_free        = !out_valid || out_ready;
    load_out         = slot_free && ((state == ST_CHUNK) || (state == ST_FINAL));
    in_ready         = (state == ST_IDLE);
    div_start        = (state == ST_DIV_GO);
    square_full      = sample_r * sample_r;
    cnt_inc          = samples_in_chunk + 1'b1;
    chunk_close      = chunk_end_r || (cnt_inc == CNT_W'(CHUNK_SAMPLES));
    chunk_silent     = (quotient < energy_threshold);
    chunks_seen_next = (chunks_seen == '1) ? chunks_seen : chunks_seen + 1'b1;
    run_inc          = (silent_run == '1) ? silent_run : silent_run + 1'b1;
    counting         = (chunks_seen_next >= min_chunks);
    if (!counting) begin
      silent_run_next = silent_run;
    end else if (chunk_silent) begin
      silent_run_next = run_inc;
    end else begin
      silent_run_next = '0;
    end
    auto_end = counting && chunk_silent && (run_inc >= silence_limit);
  end

  evad_divider #(
    .CNT_W(CNT_W)
  ) u_divider (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (square_sum),
    .divisor  (samples_in_chunk),
    .done     (div_done),
    .quotient (quotient)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      listening        <= 1'b0;
      square_sum       <= '0;
      samples_in_chunk <= '0;
      chunks_seen      <= '0;
      silent_run       <= '0;
      next_chunk_index <= '0;
      end_cause        <= STOP_NONE;
      out_valid        <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (kind) begin
              if (!listening) begin
                listening        <= 1'b1;
                square_sum       <= '0;
                samples_in_chunk <= '0;
                chunks_seen      <= '0;
                silent_run       <= '0;
                next_chunk_index <= '0;
              end else begin
                end_cause <= STOP_TAP;
                state     <= ST_FINAL;
              end
            end else if (listening) begin
              sample_r    <= sample;
              chunk_end_r <= chunk_end;
              state       <= ST_SQUARE;
            end
          end
        end
        ST_SQUARE: begin
          // The square of a 16-bit value is at most 2^30, so 31 bits hold it.
          square <= square_full[ENERGY_W-1:0];
          state  <= ST_ACCUM;
        end
        ST_ACCUM: begin
          square_sum       <= square_sum + {{(SUM_W-ENERGY_W){1'b0}}, square};
          samples_in_chunk <= cnt_inc;
          state            <= chunk_close ? ST_DIV_GO : ST_IDLE;
        end
        ST_DIV_GO: begin
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_done) begin
            state <= ST_CHUNK;
          end
        end
        ST_CHUNK: begin
          if (slot_free) begin
            chunk_index      <= next_chunk_index;
            energy           <= quotient;
            silent           <= chunk_silent;
            final_marker     <= 1'b0;
            stop_cause       <= STOP_NONE;
            next_chunk_index <= next_chunk_index + 1'b1;
            square_sum       <= '0;
            samples_in_chunk <= '0;
            chunks_seen      <= chunks_seen_next;
            silent_run       <= silent_run_next;
            if (auto_end) begin
              end_cause <= STOP_AUTO;
              state     <= ST_FINAL;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FINAL: begin
          if (slot_free) begin
            chunk_index      <= next_chunk_index;
            energy           <= '0;
            silent           <= 1'b0;
            final_marker     <= 1'b1;
            stop_cause       <= end_cause;
            next_chunk_index <= next_chunk_index + 1'b1;
            listening        <= 1'b0;
            square_sum       <= '0;
            samples_in_chunk <= '0;
            state            <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/evad_divider.sv */
// Restoring divider, one quotient bit per cycle, for the chunk mean-square energy.
module evad_divider
  import evad_pkg::*;
#(
  parameter int CNT_W = $clog2(CHUNK_SAMPLES_DEF + 1)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ENERGY_W+CNT_W-1:0] dividend,
  input  logic [CNT_W-1:0]          divisor,
  output logic                      done,
  output logic [ENERGY_W-1:0]       quotient
);

  localparam int STEP_W = $clog2(ENERGY_W);

  logic              busy;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;
  logic [ENERGY_W-1:0] quo;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              ge;

  // The quotient is known to fit in ENERGY_W bits, so the upper dividend bits
  // are already smaller than the divisor and load straight into the remainder.
  always_comb begin
    trial = {rem, quo[ENERGY_W-1]};
    diff  = trial - {1'b0, dvs};
    ge    = (trial >= {1'b0, dvs});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        rem  <= dividend[ENERGY_W+CNT_W-1:ENERGY_W];
        quo  <= dividend[ENERGY_W-1:0];
        dvs  <= divisor;
      end else if (busy) begin
        rem  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo  <= {quo[ENERGY_W-2:0], ge};
        step <= step + 1'b1;
        if (step == STEP_W'(ENERGY_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo;

endmodule

/* rtl/evad_checker.sv */
// Port-level checks on the detector's results, bound to the top level.
module evad_checker
  import evad_pkg::*;
(
  input logic                     clk,
  input logic                     rst,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [CHUNK_INDEX_W-1:0] chunk_index,
  input logic [ENERGY_W-1:0]      energy,
  input logic                     silent,
  input logic                     final_marker,
  input logic [1:0]               stop_cause
);

  // An end-of-turn item carries no energy and no silent flag.
  a_final_empty: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_marker |-> (energy == '0) && !silent)
    else $error("final marker carries energy or silent flag");

  a_chunk_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && !final_marker |-> stop_cause == STOP_NONE)
    else $error("chunk item carries a stop cause");

  a_final_cause: assert property (@(posedge clk) disable iff (rst)
    out_valid && final_marker |-> stop_cause == STOP_TAP || stop_cause == STOP_AUTO)
    else $error("final marker without a valid stop cause");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(chunk_index) && $stable(final_marker))
    else $error("stalled result changed");

endmodule

bind energy_vad_endpoint_detector_unit evad_checker u_evad_checker (.*);

/* tb/sv/energy_vad_endpoint_detector_unit_tb.sv */
// Self-checking testbench for the energy VAD endpoint detector: turns, chunk energy and stop rules.
module energy_vad_endpoint_detector_unit_tb;
  import evad_pkg::*;

  localparam int CHUNK       = CHUNK_SAMPLES_DEF;
  localparam int CYCLE_LIMIT = 600000;
  localparam int SETTLE      = 50;

  typedef struct {
    logic [CHUNK_INDEX_W-1:0] chunk_index;
    logic [ENERGY_W-1:0]      energy;
    logic                     silent;
    logic                     final_marker;
    stop_cause_t              stop_cause;
  } chunk_result_t;

  logic                     clk;
  logic                     rst = 1'b1;
  logic                     in_valid = 1'b0;
  logic                     in_ready;
  logic                     kind = 1'b0;
  logic signed [SAMPLE_W-1:0] sample = '0;
  logic                     chunk_end = 1'b0;
  logic                     out_valid;
  logic                     out_ready = 1'b0;
  logic [CHUNK_INDEX_W-1:0] chunk_index;
  logic [ENERGY_W-1:0]      energy;
  logic                     silent;
  logic                     final_marker;
  logic [1:0]               stop_cause;
  logic                     cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = REG_THRESHOLD;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;

  energy_vad_endpoint_detector_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .sample(sample), .chunk_end(chunk_end),
    .out_valid(out_valid), .out_ready(out_ready),
    .chunk_index(chunk_index), .energy(energy), .silent(silent),
    .final_marker(final_marker), .stop_cause(stop_cause),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // Detector state as the testbench sees it.
  logic [ENERGY_W-1:0]      thr_reg  = THRESHOLD_RESET;
  logic [COUNT8_W-1:0]      minc_reg = MIN_CHUNKS_RESET;
  logic [COUNT8_W-1:0]      lim_reg  = SILENCE_LIMIT_RESET;
  logic                     listening = 1'b0;
  longint unsigned          square_acc = 0;
  int                       chunk_fill = 0;
  int                       chunks_done = 0;
  int                       quiet_run = 0;
  logic [CHUNK_INDEX_W-1:0] next_index = '0;

  chunk_result_t pending_results[$];
  int            mismatches = 0;
  int            cycles = 0;
  int            stall = 0;
  bit            burst = 1'b0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  function automatic int draw_gap();
    return burst ? 0 : $urandom_range(0, 8);
  endfunction

  function automatic logic [SAMPLE_W-1:0] quiet_sample(int amp);
    int m;
    m = $urandom_range(0, amp);
    return $urandom_range(0, 1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
  endfunction

  task automatic close_turn(stop_cause_t cause);
    pending_results.push_back('{next_index, '0, 1'b0, 1'b1, cause});
    next_index = next_index + 1;
    listening = 1'b0;
    square_acc = 0;
    chunk_fill = 0;
  endtask

  // Advances the expected detector state by one accepted item.
  task automatic predict_item(logic k, logic [SAMPLE_W-1:0] smp, logic ce);
    int s;
    longint mag;
    logic [ENERGY_W-1:0] en;
    logic sil;
    if (k) begin
      if (!listening) begin
        listening = 1'b1;
        square_acc = 0;
        chunk_fill = 0;
        chunks_done = 0;
        quiet_run = 0;
        next_index = '0;
      end else begin
        close_turn(STOP_TAP);
      end
    end else if (listening) begin
      s = $signed(smp);
      mag = (s < 0) ? -longint'(s) : longint'(s);
      square_acc += mag * mag;
      chunk_fill++;
      if (ce || chunk_fill >= CHUNK) begin
        en = ENERGY_W'(square_acc / chunk_fill);
        sil = (en < thr_reg);
        pending_results.push_back('{next_index, en, sil, 1'b0, STOP_NONE});
        next_index = next_index + 1;
        square_acc = 0;
        chunk_fill = 0;
        if (chunks_done < 255) chunks_done++;
        if (chunks_done >= minc_reg) begin
          if (sil) begin
            if (quiet_run < 255) quiet_run++;
            if (quiet_run >= lim_reg) close_turn(STOP_AUTO);
          end else begin
            quiet_run = 0;
          end
        end
      end
    end
  endtask

  // Valid stays high after acceptance when no gap follows; the next call replaces the payload.
  task automatic send_item(logic k, logic [SAMPLE_W-1:0] smp, logic ce);
    int gap;
    in_valid <= 1'b1;
    kind <= k;
    sample <= smp;
    chunk_end <= ce;
    do @(posedge clk); while (!in_ready);
    predict_item(k, smp, ce);
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_config(logic [ENERGY_W-1:0] thr, logic [COUNT8_W-1:0] minc,
                            logic [COUNT8_W-1:0] lim);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_THRESHOLD;
    cfg_data <= thr;
    @(posedge clk);
    thr_reg = thr;
    cfg_index <= REG_MIN_CHUNKS;
    cfg_data <= CFG_DATA_W'(minc);
    @(posedge clk);
    minc_reg = minc;
    cfg_index <= REG_SILENCE_LIMIT;
    cfg_data <= CFG_DATA_W'(lim);
    @(posedge clk);
    lim_reg = lim;
    cfg_we <= 1'b0;
  endtask

  always @(posedge clk) begin
    chunk_result_t want;
    int n;
    if (rst) begin
      out_ready <= 1'b0;
      stall <= 0;
    end else if (out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: chunk_index %0d, final_marker %0d",
               chunk_index, final_marker);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        if (chunk_index !== want.chunk_index) begin
          $error("chunk_index: expected %0d, got %0d", want.chunk_index, chunk_index);
          mismatches++;
        end
        if (energy !== want.energy) begin
          $error("energy: expected %0d, got %0d", want.energy, energy);
          mismatches++;
        end
        if (silent !== want.silent) begin
          $error("silent: expected %0d, got %0d", want.silent, silent);
          mismatches++;
        end
        if (final_marker !== want.final_marker) begin
          $error("final_marker: expected %0d, got %0d", want.final_marker, final_marker);
          mismatches++;
        end
        if (stop_cause !== want.stop_cause) begin
          $error("stop_cause: expected %0d, got %0d", want.stop_cause, stop_cause);
          mismatches++;
        end
      end
      n = draw_gap();
      stall <= n;
      out_ready <= (n == 0);
    end else if (stall > 0) begin
      stall <= stall - 1;
      out_ready <= (stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Register defaults: field extremes, a dropped sample and both kinds of tap.
  task automatic test_directed_defaults();
    send_item(1'b0, 16'h1234, 1'b1);  // Ignored while idle.
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 16'h7FFF, 1'b1);
    send_item(1'b0, 16'h8000, 1'b1);
    send_item(1'b0, 16'h0000, 1'b1);
    send_item(1'b0, 16'hFFFF, 1'b0);
    send_item(1'b0, 16'h0001, 1'b1);
    send_item(1'b0, 16'h5555, 1'b1);
    send_item(1'b0, 16'hAAAA, 1'b1);
    send_item(1'b0, 16'hFF38, 1'b0);
    send_item(1'b1, 16'hFFFF, 1'b1);  // Ends the turn and drops the partial chunk.
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b1, 16'h0000, 1'b0);
  endtask

  task automatic test_stop_rules();
    set_config(31'd1000, 8'd0, 8'd1);
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 16'd10, 1'b1);
    // A silence limit of zero stops on the first counted silent chunk.
    set_config(31'd1000, 8'd0, 8'd0);
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 16'd3000, 1'b1);
    send_item(1'b0, 16'd0, 1'b1);
    // The first chunk is not counted; a loud chunk resets the silent run.
    set_config(31'd500, 8'd2, 8'd2);
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 16'd0, 1'b1);
    send_item(1'b0, 16'd0, 1'b1);
    send_item(1'b0, 16'h7000, 1'b1);
    send_item(1'b0, 16'd0, 1'b1);
    send_item(1'b0, 16'd0, 1'b1);
    // With a zero threshold nothing is silent.
    set_config(31'd0, 8'd1, 8'd1);
    send_item(1'b1, 16'h0000, 1'b0);
    send_item(1'b0, 16'd0, 1'b1);
    send_item(1'b0, 16'd0, 1'b1);
    send_item(1'b1, 16'h0000, 1'b0);
  endtask

  // A chunk that closes on the sample count alone.
  task automatic test_full_chunk();
    int i;
    set_config(THRESHOLD_RESET, MIN_CHUNKS_RESET, SILENCE_LIMIT_RESET);
    send_item(1'b1, 16'h0000, 1'b0);
    for (i = 0; i < CHUNK; i++) send_item(1'b0, 16'h8000, 1'b0);
    send_item(1'b0, 16'h0123, 1'b0);
    send_item(1'b1, 16'h0000, 1'b0);
  endtask

  task automatic test_counter_saturation();
    int i;
    // The chunk count must hold at its top value for counting to start at 255.
    set_config(31'h40000000, 8'd255, 8'd2);
    send_item(1'b1, 16'h0000, 1'b0);
    for (i = 0; i < 260; i++)
      send_item(1'b0, (i % 50 == 7) ? 16'h0000 : 16'h8000, 1'b1);
    send_item(1'b0, 16'h0000, 1'b1);
    send_item(1'b0, 16'h0000, 1'b1);
  endtask

  task automatic test_random_turns();
    int phase, sent, len, amp, roll, i;
    logic [ENERGY_W-1:0] thr;
    logic loud;
    logic ce;
    for (phase = 0; phase < 6; phase++) begin
      case (phase)
        2: thr = '0;
        3: thr = 31'h40000000;
        4: thr = ENERGY_W'($urandom) & 31'h3FFFFFFF;
        default: thr = ENERGY_W'($urandom_range(100, 5000));
      endcase
      set_config(thr, COUNT8_W'($urandom_range(0, 4)), COUNT8_W'($urandom_range(1, 4)));
      burst = (phase == 1);
      sent = 0;
      while (sent < 12) begin
        if (!listening) begin
          if ($urandom_range(0, 7) == 0) begin
            send_item(1'b0, SAMPLE_W'($urandom), 1'($urandom));
          end else begin
            send_item(1'b1, SAMPLE_W'($urandom), 1'($urandom));
            sent++;
          end
        end else begin
          roll = $urandom_range(0, 19);
          if (roll == 0) begin
            send_item(1'b1, SAMPLE_W'($urandom), 1'($urandom));
            sent++;
          end else begin
            len = ($urandom_range(0, 15) == 0) ? $urandom_range(7, 40) : $urandom_range(1, 6);
            loud = ($urandom_range(0, 2) == 0);
            amp = $urandom_range(4, 90);
            // Roll one leaves the chunk open and taps it away.
            for (i = 0; i < len && listening; i++) begin
              ce = (i == len - 1) ? (roll != 1) : ($urandom_range(0, 29) == 0);
              send_item(1'b0, loud ? SAMPLE_W'($urandom) : quiet_sample(amp), ce);
              sent++;
            end
            if (roll == 1 && listening) begin
              send_item(1'b1, SAMPLE_W'($urandom), 1'($urandom));
              sent++;
            end
          end
        end
      end
      burst = 1'b0;
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_defaults();
    test_stop_rules();
    test_full_chunk();
    test_counter_saturation();
    test_random_turns();
    wait_idle();
    if (mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
